>>> hdl/wfr_pkg.sv
// shared types and constants for the websocket frame receiver
// depends on nothing; imported by the parser, output register, top level, checker and testbench
package wfr_pkg;

    // parse phases, one-hot
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // frame opcodes that matter to the parser
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // byte counts of the extended length and masking key fields
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // one result item
    typedef struct packed {
        logic       has_data;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       final_flag;
        logic       frame_end;
        logic       message_end;
    } result_t;

endpackage

>>> hdl/wfr_in_stage.sv
// input register stage: holds one received byte until the parser takes it
// depends on nothing else
module wfr_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       in_xfer;

    // free when empty or when the held byte leaves this cycle
    assign s_ready = !vld_reg || take;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        vld_next = vld_reg;
        if (in_xfer) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // byte register, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            byte_reg <= s_data_byte;
        end
    end

    assign byte_valid = vld_reg;
    assign byte_data  = byte_reg;

endmodule

>>> hdl/wfr_parser.sv
// frame parser: header, extended length, masking key and payload unmasking
// depends on wfr_pkg
module wfr_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    output logic             emit,
    output wfr_pkg::result_t result
);
    import wfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  offset_reg, offset_next;
    logic        stopped_reg, stopped_next;

    logic [6:0]  len7;
    logic [63:0] ext_len;
    logic [3:0]  left_dec;
    logic [63:0] rem_dec;
    logic [7:0]  key_byte;
    logic        after_len;
    logic        hdr_done;
    logic [63:0] len_val;
    logic        last;
    logic        data_op;

    assign len7     = data_byte[6:0];
    assign ext_len  = {remain_reg[55:0], data_byte};
    assign left_dec = left_reg - 4'd1;
    assign rem_dec  = remain_reg - 64'd1;
    assign data_op  = (opcode_reg == OP_CONT) || (opcode_reg == OP_TEXT) ||
                      (opcode_reg == OP_BINARY);

    // key byte for the current offset, first received key byte first
    always_comb begin
        unique case (offset_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next state and result for the byte at the parser input
    always_comb begin
        phase_next   = phase_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        left_next    = left_reg;
        remain_next  = remain_reg;
        key_next     = key_reg;
        offset_next  = offset_reg;
        stopped_next = stopped_reg;
        after_len    = 1'b0;
        hdr_done     = 1'b0;
        len_val      = remain_reg;
        emit         = 1'b0;
        last         = 1'b0;
        result       = '0;

        if (!stopped_reg) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    fin_next    = data_byte[7];
                    opcode_next = data_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    mask_next   = data_byte[7];
                    key_next    = '0;
                    remain_next = '0;
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                        left_next  = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        phase_next = PH_EXT;
                    end else begin
                        len_val     = {57'd0, len7};
                        remain_next = {57'd0, len7};
                        after_len   = 1'b1;
                    end
                end
                PH_EXT: begin
                    remain_next = ext_len;
                    left_next   = left_dec;
                    len_val     = ext_len;
                    after_len   = (left_dec == 4'd0);
                end
                PH_KEY: begin
                    key_next  = {key_reg[23:0], data_byte};
                    left_next = left_dec;
                    hdr_done  = (left_dec == 4'd0);
                end
                PH_DATA: begin
                    offset_next = offset_reg + 2'd1;
                    remain_next = rem_dec;
                    emit        = 1'b1;
                    last        = (rem_dec == 64'd0);
                    result.has_data     = 1'b1;
                    result.payload_byte = data_byte ^ key_byte;
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase

            // length complete: masking key next, or header is done
            if (after_len) begin
                if (mask_next) begin
                    left_next  = KEY_BYTES;
                    phase_next = PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            // header done: start payload or close an empty frame
            if (hdr_done) begin
                offset_next = 2'd0;
                if (len_val == 64'd0) begin
                    emit = 1'b1;
                    last = 1'b1;
                end else begin
                    phase_next = PH_DATA;
                end
            end

            // end of frame returns to header, a close frame stops the parser
            if (last) begin
                phase_next = PH_HDR0;
                if (opcode_reg == OP_CLOSE) begin
                    stopped_next = 1'b1;
                end
            end

            result.frame_opcode = opcode_reg;
            result.final_flag   = fin_reg;
            result.frame_end    = last;
            result.message_end  = last && fin_reg && data_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            left_reg    <= '0;
            remain_reg  <= '0;
            key_reg     <= '0;
            offset_reg  <= '0;
            stopped_reg <= 1'b0;
        end else if (fire) begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            left_reg    <= left_next;
            remain_reg  <= remain_next;
            key_reg     <= key_next;
            offset_reg  <= offset_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

>>> hdl/wfr_out_reg.sv
// result register between the parser and the result channel
// depends on wfr_pkg
module wfr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  wfr_pkg::result_t res_in,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             room,
    output wfr_pkg::result_t res_out
);
    import wfr_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // can take a new result when empty or when the held one transfers now
    assign room = !vld_reg || m_ready;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = vld_reg;
    assign res_out = res_reg;

endmodule

>>> hdl/websocket_frame_receiver_unit.sv
// websocket frame receiver: one byte in per cycle unless a result meets a full output, unmasked payload out
// path: a byte is held in the input stage, parsed, then held in the output register
// throughput: one byte per cycle unless a result meets a full output, set by the single-pass parse stage
// header bytes that make no result advance even while a result waits on the output register
// reset (synchronous, active low) empties both stages and returns the parser
// to the first header byte, clearing the stop after a close frame
module websocket_frame_receiver_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_has_data,
    output logic [7:0] m_payload_byte,
    output logic [3:0] m_frame_opcode,
    output logic       m_final_flag,
    output logic       m_frame_end,
    output logic       m_message_end
);
    import wfr_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       fire;
    logic       emit;
    logic       room;
    result_t    res;
    result_t    res_out;

    // a byte moves on unless it makes a result and the output is full
    assign fire = byte_valid && (!emit || room);

    wfr_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .take        (fire),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    wfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .data_byte (byte_data),
        .emit      (emit),
        .result    (res)
    );

    wfr_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire && emit),
        .res_in  (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .room    (room),
        .res_out (res_out)
    );

    assign m_has_data     = res_out.has_data;
    assign m_payload_byte = res_out.payload_byte;
    assign m_frame_opcode = res_out.frame_opcode;
    assign m_final_flag   = res_out.final_flag;
    assign m_frame_end    = res_out.frame_end;
    assign m_message_end  = res_out.message_end;

endmodule

>>> hdl/wfr_checker.sv
// port-level checks for the websocket frame receiver, bound to the top level
// depends on wfr_pkg and the top level's ports
module wfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_has_data,
    input logic [7:0] m_payload_byte,
    input logic [3:0] m_frame_opcode,
    input logic       m_final_flag,
    input logic       m_frame_end,
    input logic       m_message_end
);
    import wfr_pkg::*;

    // result channel empties right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte) &&
        $stable(m_frame_end) && $stable(m_frame_opcode))
        else $error("stalled result changed");

    // an empty frame result is a frame end with a zero byte
    a_empty_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> m_frame_end && (m_payload_byte == 8'd0))
        else $error("empty result is not a clean frame end");

    // message end only on the final frame end of a data frame
    a_msg_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_end |-> m_frame_end && m_final_flag &&
        (m_frame_opcode == OP_CONT || m_frame_opcode == OP_TEXT ||
         m_frame_opcode == OP_BINARY))
        else $error("message end on wrong result");

    // nothing follows the end of a close frame
    a_close_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_frame_end && (m_frame_opcode == OP_CLOSE) |=> !m_valid)
        else $error("result after close frame");

endmodule

bind websocket_frame_receiver_unit wfr_checker u_wfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_has_data     (m_has_data),
    .m_payload_byte (m_payload_byte),
    .m_frame_opcode (m_frame_opcode),
    .m_final_flag   (m_final_flag),
    .m_frame_end    (m_frame_end),
    .m_message_end  (m_message_end)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// testbench for websocket_frame_receiver_unit: directed table then random frames
// depends on hdl/wfr_pkg.sv and the rtl top level; predicts each result itself, but typed rows give theirs
module tb;
    import wfr_pkg::*;

    // opcodes the package leaves out
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] OP_RSVD_B = 4'hB;

    localparam int N_DIRECTED  = 24;
    localparam int ITEM_TARGET = 1000;

    // one row of the directed table; typed rows carry their own result
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       has_res;
        result_t    res;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // empty continuation frame, no fin, unmasked
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, OP_CONT, 1'b0, 1'b1, 1'b0}},
        // masked ping with two payload bytes
        '{8'h89, 1'b1, 1'b0, '0},
        '{8'h82, 1'b1, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, '0},
        '{8'h02, 1'b1, 1'b0, '0},
        '{8'h03, 1'b1, 1'b0, '0},
        '{8'h04, 1'b1, 1'b0, '0},
        '{8'hFE, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        // reserved opcode with all rsv bits set, one byte passes unchanged
        '{8'hFB, 1'b1, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, OP_RSVD_B, 1'b1, 1'b1, 1'b0}},
        // final text frame, non-minimal 64-bit length of one
        '{8'h81, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b1, '{1'b1, 8'h7F, OP_TEXT, 1'b1, 1'b1, 1'b1}}
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_has_data;
    logic [7:0] m_payload_byte;
    logic [3:0] m_frame_opcode;
    logic       m_final_flag;
    logic       m_frame_end;
    logic       m_message_end;

    // parser state mirror, at reset values
    phase_t      pr_phase      = PH_HDR0;
    logic        pr_fin        = 1'b0;
    logic [3:0]  pr_opcode     = 4'h0;
    logic        pr_masked     = 1'b0;
    logic [3:0]  pr_field_left = 4'd0;
    logic [63:0] pr_remaining  = 64'd0;
    logic [31:0] pr_key        = 32'd0;
    logic [1:0]  pr_key_idx    = 2'd0;
    logic        pr_stopped    = 1'b0;

    result_t frame_results_due [$];
    result_t due_head;
    int      fail_count  = 0;
    int      bytes_sent  = 0;
    int      burst_left  = 0;
    logic [7:0]  rdy_cycle   = 8'd0;
    logic [15:0] rdy_pattern = 16'hFFFF;

    websocket_frame_receiver_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_data     (m_has_data),
        .m_payload_byte (m_payload_byte),
        .m_frame_opcode (m_frame_opcode),
        .m_final_flag   (m_final_flag),
        .m_frame_end    (m_frame_end),
        .m_message_end  (m_message_end)
    );

    // clock, 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result for the current frame; ends the frame when last is set
    task automatic emit_result(input logic has, input logic [7:0] val, input logic last,
                               output bit got, output result_t r);
        got = 1'b1;
        r.has_data     = has;
        r.payload_byte = val;
        r.frame_opcode = pr_opcode;
        r.final_flag   = pr_fin;
        r.frame_end    = last;
        r.message_end  = last && pr_fin &&
                         (pr_opcode == OP_CONT || pr_opcode == OP_TEXT ||
                          pr_opcode == OP_BINARY);
        if (last) begin
            pr_phase = PH_HDR0;
            if (pr_opcode == OP_CLOSE) begin
                pr_stopped = 1'b1;
            end
        end
    endtask

    // all header bytes in: payload follows, or the frame is empty
    task automatic start_payload(output bit got, output result_t r);
        pr_key_idx = 2'd0;
        if (pr_remaining == 64'd0) begin
            emit_result(1'b0, 8'h00, 1'b1, got, r);
        end else begin
            pr_phase = PH_DATA;
        end
    endtask

    // length known: masking key next if the mask bit was set
    task automatic length_done(output bit got, output result_t r);
        if (pr_masked) begin
            pr_field_left = KEY_BYTES;
            pr_phase = PH_KEY;
        end else begin
            start_payload(got, r);
        end
    endtask

    // advance the mirror by one received byte, giving its result if any
    task automatic deframe_byte(input logic [7:0] b, output bit got, output result_t r);
        logic [7:0] kb;
        got = 1'b0;
        r = '0;
        if (!pr_stopped) begin
            case (pr_phase)
                PH_HDR0: begin
                    pr_fin = b[7];
                    pr_opcode = b[3:0];
                    pr_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    pr_masked = b[7];
                    pr_key = '0;
                    pr_remaining = '0;
                    if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                        pr_field_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        pr_phase = PH_EXT;
                    end else begin
                        pr_remaining = {57'd0, b[6:0]};
                        length_done(got, r);
                    end
                end
                PH_EXT: begin
                    pr_remaining = {pr_remaining[55:0], b};
                    pr_field_left = pr_field_left - 4'd1;
                    if (pr_field_left == 4'd0) begin
                        length_done(got, r);
                    end
                end
                PH_KEY: begin
                    pr_key = {pr_key[23:0], b};
                    pr_field_left = pr_field_left - 4'd1;
                    if (pr_field_left == 4'd0) begin
                        start_payload(got, r);
                    end
                end
                PH_DATA: begin
                    kb = pr_key[31 - 8 * pr_key_idx -: 8];
                    pr_key_idx = pr_key_idx + 2'd1;
                    pr_remaining = pr_remaining - 64'd1;
                    emit_result(1'b1, b ^ kb, pr_remaining == 64'd0, got, r);
                end
                default: begin
                    pr_phase = PH_HDR0;
                end
            endcase
        end
    endtask

    // one input transfer; the result due is queued at the accepting edge
    task automatic push_byte(input logic [7:0] b, input bit typed, input bit typed_has,
                             input result_t typed_res);
        bit      got;
        result_t r;
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        bytes_sent++;
        deframe_byte(b, got, r);
        if (typed) begin
            got = typed_has;
            r = typed_res;
        end
        if (got) begin
            frame_results_due = {frame_results_due, r};
        end
        // bursts of random length with random gaps
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_byte(b, 1'b0, 1'b0, '0);
    endtask

    // hold the sender off until every due result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge aclk);
    endtask

    // one well-formed frame with random header bits, length form and content
    task automatic send_frame(input bit closing);
        logic [31:0] rnd;
        logic [3:0]  op;
        logic [6:0]  code;
        logic [63:0] len;
        logic [31:0] key;
        int          sel;
        int          ext_bytes;
        rnd = $urandom;
        sel = $urandom_range(0, 9);
        ext_bytes = 0;
        if (closing) begin
            op = OP_CLOSE;
        end else if (sel < 6) begin
            op = 4'($urandom_range(0, 2));
        end else if (sel < 8) begin
            op = (sel == 6) ? OP_PING : OP_PONG;
        end else begin
            op = rnd[15:12];
            if (op == OP_CLOSE) begin
                op = OP_RSVD_B;
            end
        end
        // length: mostly short, some 7-bit maximum, some 16- and 64-bit forms
        sel = $urandom_range(0, 19);
        if (sel < 13) begin
            len = 64'($urandom_range(0, 12));
            code = len[6:0];
        end else if (sel == 13) begin
            len = rnd[9] ? 64'd125 : 64'($urandom_range(13, 125));
            code = len[6:0];
        end else if (sel < 17) begin
            len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(126, 300))
                                              : 64'($urandom_range(0, 40));
            code = LEN_EXT16;
            ext_bytes = 2;
        end else begin
            len = 64'($urandom_range(0, 40));
            code = LEN_EXT64;
            ext_bytes = 8;
        end
        send_byte({rnd[7:4], op});
        send_byte({rnd[8], code});
        for (int i = ext_bytes - 1; i >= 0; i--) begin
            send_byte(len[8 * i +: 8]);
        end
        if (rnd[8]) begin
            key = $urandom;
            for (int i = 3; i >= 0; i--) begin
                send_byte(key[8 * i +: 8]);
            end
        end
        for (longint n = 0; n < longint'(len); n++) begin
            rnd = $urandom;
            send_byte(rnd[7:0]);
        end
    endtask

    // receiver stalls on a repeating 16-bit ready pattern, redrawn when the low six counter bits wrap,
    // every fourth window with no stalls
    always @(posedge aclk) begin
        rdy_cycle <= rdy_cycle + 8'd1;
        if (rdy_cycle[5:0] == 6'd63) begin
            rdy_pattern <= (rdy_cycle[7:6] == 2'b10) ? 16'hFFFF
                                                     : 16'($urandom | $urandom);
        end
        m_ready <= rdy_pattern[rdy_cycle[3:0]];
    end

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    // compare every output transfer with the oldest due result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                $display("%0t: result with none due, expected nothing, actual byte %0h",
                         $time, m_payload_byte);
                fail_count++;
            end else begin
                due_head = frame_results_due.pop_front();
                check_field("has_data", 8'(due_head.has_data), 8'(m_has_data));
                check_field("payload_byte", due_head.payload_byte, m_payload_byte);
                check_field("frame_opcode", 8'(due_head.frame_opcode), 8'(m_frame_opcode));
                check_field("final_flag", 8'(due_head.final_flag), 8'(m_final_flag));
                check_field("frame_end", 8'(due_head.frame_end), 8'(m_frame_end));
                check_field("message_end", 8'(due_head.message_end), 8'(m_message_end));
            end
        end
    end

    // main sequence
    initial begin
        logic [31:0] rnd;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            push_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].has_res,
                      DIRECTED[i].res);
        end
        drain_results();
        while (bytes_sent < ITEM_TARGET) begin
            send_frame(1'b0);
        end
        drain_results();
        // close frame, then bytes that must all be ignored
        send_frame(1'b1);
        repeat (20) begin
            rnd = $urandom;
            send_byte(rnd[7:0]);
        end
        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
